// ----- hw/rtl/eavt_pkg.sv -----
// ----------------------------------------------------------------------------
// eavt_pkg
// Shared constants, register map, configuration and control types for the
// encoder angle and velocity tracker.
// ----------------------------------------------------------------------------
package eavt_pkg;

  // default geometry
  localparam int unsigned COUNT_BITS_DEF = 14;
  localparam int unsigned TURN_LIMIT_DEF = 2000;

  // field widths
  localparam int unsigned TS_W      = 32;
  localparam int unsigned POS_OUT_W = 26;
  localparam int unsigned VEL_W     = 32;
  localparam int unsigned ELEC_W    = 15;
  localparam int unsigned PP_W      = 7;
  localparam int unsigned OFF_W     = 14;

  // time step handling, in microseconds
  localparam int unsigned DT_W = 19;
  localparam logic [TS_W-1:0] DT_MAX     = TS_W'(500000);
  localparam logic [DT_W-1:0] DT_DEFAULT = DT_W'(1000);

  // counts per microsecond to counts per second
  localparam int unsigned SCALE_W = 20;
  localparam logic [SCALE_W-1:0] VEL_SCALE = SCALE_W'(1000000);

  // velocity saturation bounds
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  // default dividend width of the serial divider
  localparam int unsigned DIV_NUM_W_DEF = 48;

  // apb port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register reset values
  localparam logic [PP_W-1:0] PP_RESET = PP_W'(7);

  // register map, word index
  typedef enum logic [1:0] {
    REG_REVERSE     = 2'd0,
    REG_PP_COUNT    = 2'd1,
    REG_ZERO_OFFSET = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              reverse_direction;
    logic [PP_W-1:0]   pp_count;
    logic [OFF_W-1:0]  elec_zero;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic unwrap;
    logic diff;
    logic mul;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } ctrl_status_t;

endpackage

// ----- hw/rtl/eavt_stream_if.sv -----
// ----------------------------------------------------------------------------
// eavt_stream_if
// Valid/ready channels for encoder samples and tracker results.
// ----------------------------------------------------------------------------
interface eavt_sample_if #(
  parameter int unsigned COUNT_BITS = eavt_pkg::COUNT_BITS_DEF
);
  import eavt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] raw_count;
  logic [TS_W-1:0]       timestamp_us;

  modport source (output valid, raw_count, timestamp_us, input ready);
  modport sink   (input valid, raw_count, timestamp_us, output ready);
endinterface

interface eavt_result_if;
  import eavt_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [POS_OUT_W-1:0] shaft_position;
  logic signed [VEL_W-1:0]     shaft_velocity;
  logic signed [ELEC_W-1:0]    electrical_angle;

  modport source (output valid, shaft_position, shaft_velocity, electrical_angle,
                  input ready);
  modport sink   (input valid, shaft_position, shaft_velocity, electrical_angle,
                  output ready);
endinterface

// ----- hw/rtl/eavt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// eavt_cfg_regs
// APB register file: direction, pole pairs and electrical zero offset.
// ----------------------------------------------------------------------------
module eavt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eavt_pkg::APB_AW-1:0] paddr,
  input  logic [eavt_pkg::APB_DW-1:0] pwdata,
  output logic [eavt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output eavt_pkg::cfg_t              cfg
);
  import eavt_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes, unknown words are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_direction <= 1'b0;
      cfg.pp_count          <= PP_RESET;
      cfg.elec_zero         <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_REVERSE:     cfg.reverse_direction <= pwdata[0];
        REG_PP_COUNT:    cfg.pp_count          <= pwdata[PP_W-1:0];
        REG_ZERO_OFFSET: cfg.elec_zero         <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_REVERSE:     prdata = APB_DW'(cfg.reverse_direction);
      REG_PP_COUNT:    prdata = APB_DW'(cfg.pp_count);
      REG_ZERO_OFFSET: prdata = APB_DW'(cfg.elec_zero);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/eavt_divider.sv -----
// ----------------------------------------------------------------------------
// eavt_divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module eavt_divider #(
  parameter int unsigned NUM_W = eavt_pkg::DIV_NUM_W_DEF,
  parameter int unsigned DEN_W = eavt_pkg::DT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             take;

  // one trial subtraction
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    trial    = shifted - {1'b0, den};
    take     = (shifted >= {1'b0, den});
    rem_next = take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

// ----- hw/rtl/eavt_datapath.sv -----
// ----------------------------------------------------------------------------
// eavt_datapath
// Turn unwrap, position difference, scaling, division and output forming,
// each step fired by a controller command.
// ----------------------------------------------------------------------------
module eavt_datapath #(
  parameter int unsigned COUNT_BITS = eavt_pkg::COUNT_BITS_DEF,
  parameter int unsigned TURN_LIMIT = eavt_pkg::TURN_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  eavt_pkg::ctrl_cmd_t                   cmd,
  output eavt_pkg::ctrl_status_t                status,
  input  eavt_pkg::cfg_t                        cfg,
  input  logic [COUNT_BITS-1:0]                 raw_count,
  input  logic [eavt_pkg::TS_W-1:0]             timestamp_us,
  output logic signed [eavt_pkg::POS_OUT_W-1:0] shaft_position,
  output logic signed [eavt_pkg::VEL_W-1:0]     shaft_velocity,
  output logic signed [eavt_pkg::ELEC_W-1:0]    electrical_angle
);
  import eavt_pkg::*;

  localparam int unsigned TURN_W = $clog2(TURN_LIMIT + 1) + 1;
  localparam int unsigned POS_W  = TURN_W + COUNT_BITS;
  localparam int unsigned LPOS_W = POS_W + 1;
  localparam int unsigned MAG_W  = POS_W + 1;
  localparam int unsigned DIFF_W = MAG_W + 1;
  localparam int unsigned PROD_W = MAG_W + SCALE_W;
  localparam int unsigned SH_W   = (POS_W + 1 > POS_OUT_W) ? POS_W + 1 : POS_OUT_W;
  localparam int unsigned EW     = ((COUNT_BITS > OFF_W) ? COUNT_BITS : OFF_W) + 1;
  localparam int unsigned EP_W   = COUNT_BITS + PP_W;

  localparam logic signed [TURN_W-1:0] TL_POS = TURN_W'(TURN_LIMIT);
  localparam logic signed [TURN_W-1:0] TL_NEG = -TL_POS;
  localparam logic signed [TURN_W-1:0] TURN_ONE = TURN_W'(1);
  localparam logic signed [LPOS_W-1:0] TURN_SPAN =
    LPOS_W'(longint'(TURN_LIMIT) << COUNT_BITS);
  localparam logic [COUNT_BITS+2:0] WRAP_LIM = (COUNT_BITS + 3)'(4) << COUNT_BITS;

  // sample and tracking state
  logic [COUNT_BITS-1:0]     raw_q;
  logic [TS_W-1:0]           ts_q;
  logic [COUNT_BITS-1:0]     last_raw;
  logic signed [TURN_W-1:0]  turn_count;
  logic signed [LPOS_W-1:0]  last_position;
  logic [TS_W-1:0]           last_timestamp;

  // intermediate results
  logic signed [POS_W-1:0]   pos_q;
  logic [DT_W-1:0]           dt_q;
  logic [MAG_W-1:0]          diff_mag;
  logic                      diff_neg;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         quot;

  // unwrap logic
  logic signed [COUNT_BITS:0] jump;
  logic [COUNT_BITS-1:0]      jump_mag;
  logic [COUNT_BITS+2:0]      jump5;
  logic                       wrap;
  logic signed [TURN_W-1:0]   turn_step;
  logic signed [TURN_W-1:0]   tc_wrapped;
  logic signed [TURN_W-1:0]   tc_next;
  logic signed [LPOS_W-1:0]   lpos_adj;
  logic [TS_W-1:0]            dt_raw;
  logic [DT_W-1:0]            dt_sel;

  always_comb begin
    jump     = $signed({1'b0, raw_q}) - $signed({1'b0, last_raw});
    jump_mag = jump[COUNT_BITS] ? COUNT_BITS'(-jump) : jump[COUNT_BITS-1:0];
    jump5    = {1'b0, jump_mag, 2'b00} + (COUNT_BITS + 3)'(jump_mag);
    wrap     = (jump5 > WRAP_LIM);
    // a forward jump past the wrap means the shaft went back a turn
    if (!wrap) begin
      turn_step = '0;
    end else if (jump[COUNT_BITS]) begin
      turn_step = TURN_ONE;
    end else begin
      turn_step = -TURN_ONE;
    end
    tc_wrapped = turn_count + turn_step;
    // turn counter limit, the old position follows so velocity has no step
    if (tc_wrapped >= TL_POS) begin
      tc_next  = '0;
      lpos_adj = last_position - TURN_SPAN;
    end else if (tc_wrapped <= TL_NEG) begin
      tc_next  = '0;
      lpos_adj = last_position + TURN_SPAN;
    end else begin
      tc_next  = tc_wrapped;
      lpos_adj = last_position;
    end
    // time step with fallback
    dt_raw = ts_q - last_timestamp;
    if (dt_raw == '0 || dt_raw > DT_MAX) begin
      dt_sel = DT_DEFAULT;
    end else begin
      dt_sel = dt_raw[DT_W-1:0];
    end
  end

  // position difference
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    diff = DIFF_W'(pos_q) - DIFF_W'(last_position);
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw       <= '0;
      turn_count     <= '0;
      last_position  <= '0;
      last_timestamp <= '0;
    end else if (cmd.unwrap) begin
      last_raw       <= raw_q;
      turn_count     <= tc_next;
      last_position  <= lpos_adj;
      last_timestamp <= ts_q;
    end else if (cmd.diff) begin
      last_position  <= LPOS_W'(pos_q);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_q <= raw_count;
      ts_q  <= timestamp_us;
    end
    if (cmd.unwrap) begin
      pos_q <= $signed({tc_next, raw_q});
      dt_q  <= dt_sel;
    end
    if (cmd.diff) begin
      diff_neg <= diff[DIFF_W-1];
      diff_mag <= diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff_mag) * PROD_W'(VEL_SCALE);
    end
  end

  // scaled difference over time step
  eavt_divider #(
    .NUM_W(PROD_W),
    .DEN_W(DT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (dt_q),
    .busy     (status.div_busy),
    .quotient (quot)
  );

  // output forming: direction, saturation, electrical angle
  logic                     vel_neg;
  logic                     over_pos;
  logic                     over_neg;
  logic [VEL_W-1:0]         vel_mag;
  logic [VEL_W-1:0]         vel_c;
  logic signed [SH_W-1:0]   pos_ext;
  logic signed [SH_W-1:0]   shaft_full;
  logic [EP_W-1:0]          elec_prod;
  logic signed [EW-1:0]     elec_full;

  always_comb begin
    vel_neg  = diff_neg ^ cfg.reverse_direction;
    vel_mag  = quot[VEL_W-1:0];
    over_pos = |quot[PROD_W-1:VEL_W-1];
    over_neg = (|quot[PROD_W-1:VEL_W]) || (quot[VEL_W-1] && (|quot[VEL_W-2:0]));
    if (!vel_neg) begin
      vel_c = over_pos ? VEL_MAX : vel_mag;
    end else begin
      vel_c = over_neg ? VEL_MIN : -vel_mag;
    end
    pos_ext    = SH_W'(pos_q);
    shaft_full = cfg.reverse_direction ? -pos_ext : pos_ext;
    elec_prod  = EP_W'(shaft_full[COUNT_BITS-1:0]) * EP_W'(cfg.pp_count);
    elec_full  = EW'(elec_prod[COUNT_BITS-1:0]) - EW'(cfg.elec_zero);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      shaft_position   <= shaft_full[POS_OUT_W-1:0];
      shaft_velocity   <= vel_c;
      electrical_angle <= elec_full[ELEC_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/eavt_ctrl.sv -----
// ----------------------------------------------------------------------------
// eavt_ctrl
// Sequencer: takes one item, walks the datapath through its steps and
// holds the result valid until taken.
// ----------------------------------------------------------------------------
module eavt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output eavt_pkg::ctrl_cmd_t    cmd,
  input  eavt_pkg::ctrl_status_t status
);
  import eavt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UNWRAP = 7'b0000010,
    ST_DIFF   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_START  = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UNWRAP;
        end
      end
      ST_UNWRAP: begin
        cmd.unwrap = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/encoder_angle_velocity_tracker.sv -----
// ----------------------------------------------------------------------------
// encoder_angle_velocity_tracker
// Multi-turn unwrap of an absolute encoder, velocity in counts per second and
// electrical angle, with an APB register port.
// ----------------------------------------------------------------------------
// steps per item: capture, unwrap, position difference, scaling, divider
//   start, division, output load; the divider width P is the position
//   difference bits plus 20 (47 at default settings), one quotient bit per
//   cycle for the velocity; a new item is taken only after the last is loaded
// a finished result waits in the output register while the next item is taken
// reset (rst, synchronous): tracking state and counters cleared, registers to
//   reverse 0, pole pairs 7, offset 0
module encoder_angle_velocity_tracker #(
  parameter int unsigned COUNT_BITS = eavt_pkg::COUNT_BITS_DEF,
  parameter int unsigned TURN_LIMIT = eavt_pkg::TURN_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eavt_pkg::APB_AW-1:0] paddr,
  input  logic [eavt_pkg::APB_DW-1:0] pwdata,
  output logic [eavt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  eavt_sample_if.sink                 enc_sample,
  eavt_result_if.source               track_result
);
  import eavt_pkg::*;

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // configuration registers
  eavt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  eavt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (enc_sample.valid),
    .in_ready  (enc_sample.ready),
    .out_valid (track_result.valid),
    .out_ready (track_result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic
  eavt_datapath #(
    .COUNT_BITS(COUNT_BITS),
    .TURN_LIMIT(TURN_LIMIT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg              (cfg),
    .raw_count        (enc_sample.raw_count),
    .timestamp_us     (enc_sample.timestamp_us),
    .shaft_position   (track_result.shaft_position),
    .shaft_velocity   (track_result.shaft_velocity),
    .electrical_angle (track_result.electrical_angle)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder angle and velocity tracker. A table of
// directed samples covers wraps, the wrap threshold, bad time steps, timestamp
// rollover and velocity saturation. Random phases under several register
// settings follow, then fast spins in both directions across many turns.
// Every result is checked against an in-bench model or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_top;
  import eavt_pkg::*;

  localparam longint TURN_COUNTS = longint'(1) << COUNT_BITS_DEF;
  localparam int     TURN_LIMIT = TURN_LIMIT_DEF;
  localparam longint VEL_HI = 2147483647;
  localparam longint VEL_LO = -VEL_HI - 1;

  // write target outside the register map
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam logic [1:0] SPIN_NONE = 2'd0;
  localparam logic [1:0] SPIN_UP   = 2'd1;
  localparam logic [1:0] SPIN_DOWN = 2'd2;

  localparam int IDLE_PCT         = 22;
  localparam int HOLD_CYCLES      = 600;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int SPIN_TURNS       = 40;
  localparam int DRAIN_CYCLES     = 100;
  localparam int CYCLE_LIMIT      = 3000000;

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos;
    logic [VEL_W-1:0]     vel;
    logic [ELEC_W-1:0]    elec;
  } motion_t;

  typedef struct packed {
    logic [COUNT_BITS_DEF-1:0] raw;
    logic [TS_W-1:0]           stamp;
    logic                      typed;
    motion_t                   result;
  } sample_row_t;

  typedef struct packed {
    cfg_t       cfg;
    logic       bad_write;
    logic       hold_off;
    logic       idle;
    logic [1:0] spin;
  } phase_t;

  // directed samples, fixed results where they are plain to see
  localparam int NUM_ROWS = 19;
  localparam sample_row_t SCRIPT [NUM_ROWS] = '{
    '{14'd0,     32'd0 + 32'd1000, 1'b1, '{26'd0, 32'd0, 15'd0}},
    '{14'd16383, 32'd2000,         1'b1, '{-26'sd1, -32'sd1000, 15'd16377}},
    '{14'd0,     32'd3000,         1'b1, '{26'd0, 32'd1000, 15'd0}},
    '{14'd13107, 32'd4000,         1'b0, '0},
    '{14'd0,     32'd5000,         1'b0, '0},
    '{14'd13108, 32'd6000,         1'b0, '0},
    '{14'd0,     32'd6000,         1'b1, '{26'd0, 32'd3276000, 15'd0}},
    '{14'd100,   32'd5000,         1'b1, '{26'd100, 32'd100000, 15'd700}},
    '{14'd200,   32'd505000,       1'b1, '{26'd200, 32'd200, 15'd1400}},
    '{14'd300,   32'd1005001,      1'b1, '{26'd300, 32'd100000, 15'd2100}},
    '{14'd5300,  32'd1005002,      1'b1, '{26'd5300, 32'h7FFF_FFFF, 15'd4332}},
    '{14'd300,   32'd1005003,      1'b1, '{26'd300, 32'h8000_0000, 15'd2100}},
    '{14'd16383, 32'hFFFF_FFFF,    1'b1, '{-26'sd1, -32'sd301000, 15'd16377}},
    '{14'd16283, 32'd99,           1'b1, '{-26'sd101, -32'sd1000000, 15'd15677}},
    '{14'd8192,  32'd1099,         1'b0, '0},
    '{14'd0,     32'd0,            1'b0, '0},
    '{14'd1,     32'd2,            1'b0, '0},
    '{14'd2,     32'd5,            1'b0, '0},
    '{14'd1,     32'd8,            1'b0, '0}
  };

  // register settings, one per phase
  localparam int NUM_PHASES = 8;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{'{1'b1, 7'd64,  14'd16383}, 1'b0, 1'b0, 1'b1, SPIN_NONE},
    '{'{1'b0, 7'd1,   14'd0},     1'b0, 1'b0, 1'b1, SPIN_NONE},
    '{'{1'b1, 7'd0,   14'd8191},  1'b1, 1'b0, 1'b1, SPIN_NONE},
    '{'{1'b0, 7'd127, 14'd1},     1'b0, 1'b1, 1'b1, SPIN_NONE},
    '{'{1'b1, 7'd33,  14'd12345}, 1'b0, 1'b0, 1'b0, SPIN_NONE},
    '{'{1'b0, 7'd7,   14'd0},     1'b0, 1'b0, 1'b1, SPIN_NONE},
    '{'{1'b0, 7'd7,   14'd100},   1'b0, 1'b0, 1'b0, SPIN_UP},
    '{'{1'b1, 7'd5,   14'd16383}, 1'b0, 1'b0, 1'b0, SPIN_DOWN}
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  eavt_sample_if enc_sample_ch ();
  eavt_result_if track_result_ch ();

  encoder_angle_velocity_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .enc_sample   (enc_sample_ch),
    .track_result (track_result_ch)
  );

  // tracking state and register copy of the model
  logic [COUNT_BITS_DEF-1:0] trk_raw;
  int                        trk_turns;
  longint                    trk_pos;
  logic [TS_W-1:0]           trk_stamp;
  cfg_t                      cfg;

  motion_t                   motion_q [$];
  int                        mismatches;
  bit                        src_idle_en;
  bit                        snk_idle_en;
  int                        hold_requests;
  int                        hold_served;
  int                        hold_left;
  int                        cycle_count;

  // stimulus generator position
  logic [COUNT_BITS_DEF-1:0] gen_raw;
  logic [TS_W-1:0]           gen_stamp;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // unwrap, velocity and electrical angle for one sample
  function automatic motion_t track_sample(input logic [COUNT_BITS_DEF-1:0] raw,
                                           input logic [TS_W-1:0] now);
    longint          jump;
    longint          pos;
    longint          vel;
    longint          shaft;
    longint          elec;
    logic [TS_W-1:0] dt;
    motion_t         m;
    jump = longint'(raw) - longint'(trk_raw);
    if (5 * (jump < 0 ? -jump : jump) > 4 * TURN_COUNTS)
      trk_turns += (jump > 0) ? -1 : 1;
    trk_raw = raw;

    // turn counter limit, position history shifted to keep velocity smooth
    if (trk_turns >= TURN_LIMIT) begin
      trk_turns = 0;
      trk_pos -= longint'(TURN_LIMIT) * TURN_COUNTS;
    end else if (trk_turns <= -TURN_LIMIT) begin
      trk_turns = 0;
      trk_pos += longint'(TURN_LIMIT) * TURN_COUNTS;
    end
    pos = longint'(trk_turns) * TURN_COUNTS + longint'(raw);

    // zero, negative or overlong time steps fall back to the default
    dt = now - trk_stamp;
    if (dt == '0 || dt > DT_MAX)
      dt = TS_W'(DT_DEFAULT);
    vel = ((pos - trk_pos) * longint'(VEL_SCALE)) / longint'(dt);
    trk_pos = pos;
    trk_stamp = now;

    shaft = cfg.reverse_direction ? -pos : pos;
    if (cfg.reverse_direction)
      vel = -vel;
    if (vel > VEL_HI)
      vel = VEL_HI;
    if (vel < VEL_LO)
      vel = VEL_LO;
    elec = (shaft * longint'(cfg.pp_count)) & (TURN_COUNTS - 1);
    elec -= longint'(cfg.elec_zero);

    m.pos = shaft[POS_OUT_W-1:0];
    m.vel = vel[VEL_W-1:0];
    m.elec = elec[ELEC_W-1:0];
    return m;
  endfunction

  // offer one item, predict its result once it is taken
  task automatic offer_sample(input logic [COUNT_BITS_DEF-1:0] raw,
                              input logic [TS_W-1:0] stamp,
                              input logic typed, input motion_t result);
    motion_t predicted;
    while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      enc_sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    enc_sample_ch.valid        <= 1'b1;
    enc_sample_ch.raw_count    <= raw;
    enc_sample_ch.timestamp_us <= stamp;
    do begin
      @(posedge clk);
    end while (!enc_sample_ch.ready);
    predicted = track_sample(raw, stamp);
    motion_q.push_back(typed ? result : predicted);
    gen_raw = raw;
    gen_stamp = stamp;
  endtask

  // wait until every predicted result has come back
  task automatic wait_results_drained();
    enc_sample_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (motion_q.size() != 0);
  endtask

  // one apb transfer, setup then access
  task automatic apb_xfer(input logic write, input logic [1:0] idx,
                          input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all registers with junk above their width, then read them back
  task automatic program_cfg(input phase_t ph);
    logic [APB_DW-1:0] junk;
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] want [3];
    junk = $urandom();
    apb_xfer(1'b1, REG_REVERSE, {junk[31:1], ph.cfg.reverse_direction}, rd);
    apb_xfer(1'b1, REG_PP_COUNT, {junk[31:PP_W], ph.cfg.pp_count}, rd);
    apb_xfer(1'b1, REG_ZERO_OFFSET, {junk[31:OFF_W], ph.cfg.elec_zero}, rd);
    if (ph.bad_write)
      apb_xfer(1'b1, REG_NONE, $urandom(), rd);
    cfg = ph.cfg;
    want[REG_REVERSE]     = APB_DW'(ph.cfg.reverse_direction);
    want[REG_PP_COUNT]    = APB_DW'(ph.cfg.pp_count);
    want[REG_ZERO_OFFSET] = APB_DW'(ph.cfg.elec_zero);
    for (int i = 0; i < 3; i++) begin
      apb_xfer(1'b0, 2'(i), '0, rd);
      if (rd !== want[i]) begin
        $error("register %0d: expected %0h, got %0h", i, want[i], rd);
        mismatches++;
      end
    end
  endtask

  // fast rotation, three samples per turn
  task automatic spin_fast(input bit forward);
    logic [COUNT_BITS_DEF-1:0] band [3];
    repeat (SPIN_TURNS) begin
      band[0] = COUNT_BITS_DEF'($urandom_range(0, 1000));
      band[1] = COUNT_BITS_DEF'($urandom_range(6000, 9000));
      band[2] = COUNT_BITS_DEF'($urandom_range(15000, 16383));
      for (int i = 0; i < 3; i++)
        offer_sample(band[forward ? i : 2 - i], gen_stamp + $urandom_range(1, 1000),
                     1'b0, '0);
    end
  endtask

  // result side: ready with random stalls and a requested long hold-off
  initial begin
    motion_t want;
    track_result_ch.ready <= 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && track_result_ch.valid && track_result_ch.ready) begin
        if (motion_q.size() == 0) begin
          $error("result with no item pending");
          mismatches++;
        end else begin
          want = motion_q.pop_front();
          if (track_result_ch.shaft_position !== want.pos) begin
            $error("shaft_position: expected %0d, got %0d",
                   $signed(want.pos), track_result_ch.shaft_position);
            mismatches++;
          end
          if (track_result_ch.shaft_velocity !== want.vel) begin
            $error("shaft_velocity: expected %0d, got %0d",
                   $signed(want.vel), track_result_ch.shaft_velocity);
            mismatches++;
          end
          if (track_result_ch.electrical_angle !== want.elec) begin
            $error("electrical_angle: expected %0d, got %0d",
                   $signed(want.elec), track_result_ch.electrical_angle);
            mismatches++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        track_result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        track_result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        track_result_ch.ready <= !(snk_idle_en && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    int                        sel;
    int                        step;
    logic [COUNT_BITS_DEF-1:0] raw;
    logic [TS_W-1:0]           stamp;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    enc_sample_ch.valid        <= 1'b0;
    enc_sample_ch.raw_count    <= '0;
    enc_sample_ch.timestamp_us <= '0;
    mismatches = 0;
    hold_requests = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    trk_raw = '0;
    trk_turns = 0;
    trk_pos = 0;
    trk_stamp = '0;
    cfg = '{1'b0, PP_RESET, '0};
    gen_raw = '0;
    gen_stamp = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed samples under reset settings
    for (int i = 0; i < NUM_ROWS; i++)
      offer_sample(SCRIPT[i].raw, SCRIPT[i].stamp, SCRIPT[i].typed, SCRIPT[i].result);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results_drained();
      program_cfg(PHASES[p]);
      src_idle_en = PHASES[p].idle;
      snk_idle_en = PHASES[p].idle;
      if (PHASES[p].hold_off)
        hold_requests++;
      if (PHASES[p].spin != SPIN_NONE) begin
        spin_fast(PHASES[p].spin == SPIN_UP);
      end else begin
        repeat (RANDOM_PER_PHASE) begin
          sel = $urandom_range(0, 99);
          raw = gen_raw + COUNT_BITS_DEF'($urandom_range(0, 200) - 100);
          // short steps now and then push the velocity into saturation
          stamp = gen_stamp + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                            : $urandom_range(1, 3000));
          if (sel < 55) begin
            // smooth rotation either way
            raw = gen_raw + COUNT_BITS_DEF'($urandom_range(0, 6000) - 3000);
          end else if (sel < 70) begin
            // jumps right around the wrap threshold
            step = $urandom_range(13100, 13115);
            if (gen_raw >= step)
              raw = COUNT_BITS_DEF'(gen_raw - step);
            else if (gen_raw + step < TURN_COUNTS)
              raw = COUNT_BITS_DEF'(gen_raw + step);
            else
              raw = COUNT_BITS_DEF'($urandom());
          end else if (sel < 85) begin
            raw = COUNT_BITS_DEF'($urandom());
            stamp = $urandom();
          end else begin
            // bad time steps and the largest good one
            case ($urandom_range(0, 3))
              0: stamp = gen_stamp;
              1: stamp = gen_stamp - $urandom_range(1, 2000000);
              2: stamp = gen_stamp + DT_MAX + $urandom_range(1, 100000000);
              default: stamp = gen_stamp + DT_MAX;
            endcase
          end
          offer_sample(raw, stamp, 1'b0, '0);
        end
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
